### rtl/core/bmp24_pkg.sv
// shared types and constants for the bitmap pixel stream decoder
`timescale 1ns / 1ps
`default_nettype none

package bmp24_pkg;

    // header byte positions
    localparam logic [7:0] HDR_OFFSET_POS = 8'h0A;
    localparam logic [7:0] HDR_WIDTH_LO   = 8'h12;
    localparam logic [7:0] HDR_WIDTH_HI   = 8'h13;
    localparam logic [7:0] HDR_HEIGHT_LO  = 8'h16;
    localparam logic [7:0] HDR_HEIGHT_HI  = 8'h17;
    localparam logic [7:0] HDR_END        = 8'h18;

    // configuration register indexes
    localparam logic [1:0] CFG_START_X     = 2'd0;
    localparam logic [1:0] CFG_START_Y     = 2'd1;
    localparam logic [1:0] CFG_CLIP_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_CLIP_HEIGHT = 2'd3;

    // byte position inside a blue, green, red triple
    localparam logic [1:0] PHASE_BLUE  = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_RED   = 2'd2;

    // register reset values
    localparam logic [10:0] START_X_RST     = 11'd0;
    localparam logic [10:0] START_Y_RST     = 11'd48;
    localparam logic [12:0] CLIP_WIDTH_RST  = 13'd1024;
    localparam logic [12:0] CLIP_HEIGHT_RST = 13'd720;

    typedef logic [15:0] dim_t;
    typedef logic [12:0] coord_t;
    typedef logic [23:0] color_t;

endpackage

`default_nettype wire

### rtl/core/bmp24_pixel_stream_decoder.sv
// top level of the 24-bit bottom-up bitmap pixel stream decoder
//
//  channel | beat fields                                  | handshake
//  --------+----------------------------------------------+--------------------------
//  byte    | file_byte[7:0], first_byte                   | byte_valid / byte_ready
//  pixel   | pixel_x[12:0], pixel_y[12:0],                | pixel_valid / pixel_ready
//          | pixel_color[23:0], last                      |
//  cfg     | cfg_index[1:0], cfg_data[12:0]               | cfg_valid / cfg_ready
//
//  one byte beat per cycle while byte_ready is high; parse state and the pixel are worked out in the
//  accepting cycle and the pixel shows on the output register in the next cycle
//  byte_ready drops only while a pixel sits in the output register unclaimed
//  reset clears parse state and loads register defaults; no clearing pass
//  cfg_ready is always high, a write takes effect on the next cycle
`timescale 1ns / 1ps
`default_nettype none

module bmp24_pixel_stream_decoder
    import bmp24_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte stream
    input  wire logic [7:0]  file_byte,
    input  wire logic        first_byte,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    // pixel stream
    output logic [12:0]      pixel_x,
    output logic [12:0]      pixel_y,
    output logic [23:0]      pixel_color,
    output logic             last,
    output logic             pixel_valid,
    input  wire logic        pixel_ready,
    // configuration writes
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);

    // configuration registers
    logic [10:0] start_x_reg;
    logic [10:0] start_y_reg;
    logic [12:0] clip_width_reg;
    logic [12:0] clip_height_reg;

    // parse state
    logic [7:0]  header_pos_reg,   header_pos_next;
    logic [7:0]  data_offset_reg,  data_offset_next;
    dim_t        image_width_reg,  image_width_next;
    dim_t        image_height_reg, image_height_next;
    dim_t        column_reg,       column_next;
    dim_t        row_reg,          row_next;
    logic [1:0]  phase_reg,        phase_next;
    logic [15:0] partial_reg,      partial_next;
    logic        done_reg,         done_next;

    // output register
    logic        pixel_valid_reg;
    coord_t      pixel_x_reg,     pixel_x_next;
    coord_t      pixel_y_reg,     pixel_y_next;
    color_t      pixel_color_reg, pixel_color_next;
    logic        last_reg,        last_next;
    logic        emit;

    // state as seen by the current byte, after a restart mark
    logic [7:0]  cur_header_pos;
    logic [7:0]  cur_data_offset;
    dim_t        cur_image_width;
    dim_t        cur_image_height;
    dim_t        cur_column;
    dim_t        cur_row;
    logic [1:0]  cur_phase;
    logic [15:0] cur_partial;
    logic        cur_done;

    logic [7:0]  data_start;
    dim_t        draw_w;
    dim_t        draw_h;
    dim_t        column_inc;
    logic        byte_accept;

    assign byte_ready  = !pixel_valid_reg || pixel_ready;
    assign byte_accept = byte_valid && byte_ready;
    assign cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= START_X_RST;
            start_y_reg     <= START_Y_RST;
            clip_width_reg  <= CLIP_WIDTH_RST;
            clip_height_reg <= CLIP_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_X:     start_x_reg     <= cfg_data[10:0];
                CFG_START_Y:     start_y_reg     <= cfg_data[10:0];
                CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_data;
                CFG_CLIP_HEIGHT: clip_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // a start mark wipes parse state before the byte is looked at
    always_comb
    begin
        if (first_byte)
        begin
            cur_header_pos   = '0;
            cur_data_offset  = '0;
            cur_image_width  = '0;
            cur_image_height = '0;
            cur_column       = '0;
            cur_row          = '0;
            cur_phase        = PHASE_BLUE;
            cur_partial      = '0;
            cur_done         = 1'b0;
        end
        else
        begin
            cur_header_pos   = header_pos_reg;
            cur_data_offset  = data_offset_reg;
            cur_image_width  = image_width_reg;
            cur_image_height = image_height_reg;
            cur_column       = column_reg;
            cur_row          = row_reg;
            cur_phase        = phase_reg;
            cur_partial      = partial_reg;
            cur_done         = done_reg;
        end
    end

    // pixel data never starts inside the size fields
    assign data_start = (cur_data_offset < HDR_END) ? HDR_END : cur_data_offset;

    // drawn window is the smaller of image and clip sizes
    assign draw_w = (cur_image_width < {3'b000, clip_width_reg})
                  ? cur_image_width : {3'b000, clip_width_reg};
    assign draw_h = (cur_image_height < {3'b000, clip_height_reg})
                  ? cur_image_height : {3'b000, clip_height_reg};

    assign column_inc = cur_column + 16'd1;

    // next parse state and the pixel for this byte
    always_comb
    begin
        header_pos_next   = cur_header_pos;
        data_offset_next  = cur_data_offset;
        image_width_next  = cur_image_width;
        image_height_next = cur_image_height;
        column_next       = cur_column;
        row_next          = cur_row;
        phase_next        = cur_phase;
        partial_next      = cur_partial;
        done_next         = cur_done;
        emit              = 1'b0;
        last_next         = 1'b0;
        pixel_color_next  = {file_byte, cur_partial};
        pixel_x_next      = coord_t'({2'b00, start_x_reg} + cur_column[12:0]);
        pixel_y_next      = coord_t'({2'b00, start_y_reg} + draw_h[12:0]
                                     - 13'd1 - cur_row[12:0]);

        if (cur_header_pos < data_start)
        begin
            // header: pick out offset, width and height bytes
            unique case (cur_header_pos)
                HDR_OFFSET_POS: data_offset_next = file_byte;
                HDR_WIDTH_LO:   image_width_next = {cur_image_width[15:8], file_byte};
                HDR_WIDTH_HI:   image_width_next = {file_byte, cur_image_width[7:0]};
                HDR_HEIGHT_LO:  image_height_next = {cur_image_height[15:8], file_byte};
                HDR_HEIGHT_HI:  image_height_next = {file_byte, cur_image_height[7:0]};
                default:        ;
            endcase
            header_pos_next = cur_header_pos + 8'd1;
        end
        else if (cur_done)
        begin
            // trailing bytes after the image are dropped
        end
        else if (draw_w == '0 || draw_h == '0)
        begin
            done_next = 1'b1;
        end
        else
        begin
            case (cur_phase)
                PHASE_BLUE:
                begin
                    partial_next = {8'h00, file_byte};
                    phase_next   = PHASE_GREEN;
                end
                PHASE_GREEN:
                begin
                    partial_next = {file_byte, cur_partial[7:0]};
                    phase_next   = PHASE_RED;
                end
                default:
                begin
                    // red byte closes the pixel
                    phase_next = PHASE_BLUE;
                    if (column_inc >= cur_image_width)
                    begin
                        column_next = '0;
                        row_next    = cur_row + 16'd1;
                    end
                    else
                    begin
                        column_next = column_inc;
                    end
                    if (cur_column < draw_w && cur_row < draw_h)
                    begin
                        emit      = 1'b1;
                        last_next = (cur_column == draw_w - 16'd1)
                                 && (cur_row == draw_h - 16'd1);
                        if (last_next)
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // parse state advances on every accepted byte beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg   <= '0;
            data_offset_reg  <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            column_reg       <= '0;
            row_reg          <= '0;
            phase_reg        <= PHASE_BLUE;
            partial_reg      <= '0;
            done_reg         <= 1'b0;
        end
        else if (byte_accept)
        begin
            header_pos_reg   <= header_pos_next;
            data_offset_reg  <= data_offset_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            phase_reg        <= phase_next;
            partial_reg      <= partial_next;
            done_reg         <= done_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
        end
        else if (byte_accept)
        begin
            pixel_valid_reg <= emit;
        end
        else if (pixel_ready)
        begin
            pixel_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (byte_accept && emit)
        begin
            pixel_x_reg     <= pixel_x_next;
            pixel_y_reg     <= pixel_y_next;
            pixel_color_reg <= pixel_color_next;
            last_reg        <= last_next;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

### rtl/core/bmp24_checker.sv
// port-level checks for the bitmap pixel stream decoder, with bind
`timescale 1ns / 1ps
`default_nettype none

module bmp24_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_valid,
    input wire logic        byte_ready,
    input wire logic [12:0] pixel_x,
    input wire logic [12:0] pixel_y,
    input wire logic [23:0] pixel_color,
    input wire logic        last,
    input wire logic        pixel_valid,
    input wire logic        pixel_ready,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // a stalled pixel beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_x)
            && $stable(pixel_y) && $stable(pixel_color) && $stable(last))
    else $error("pixel beat changed while stalled");

    // the byte side stalls only behind an unclaimed pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> pixel_valid && !pixel_ready)
    else $error("byte_ready low without output back-pressure");

    // a new pixel only follows an accepted byte beat
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !$past(pixel_valid && !pixel_ready)
            |-> $past(byte_valid && byte_ready))
    else $error("pixel beat without a byte beat");

    // configuration writes never stall
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind bmp24_pixel_stream_decoder bmp24_checker u_bmp24_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last        (last),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);

`default_nettype wire

### sim/tb_top.sv
// self-checking testbench for the bitmap pixel stream decoder: byte files in, pixels checked out
`timescale 1ns / 1ps

module tb_top;
    import bmp24_pkg::*;

    // run bounds: slowest legal run is far below this
    localparam int unsigned CYCLE_LIMIT     = 400000;
    // output register latency, padded
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned BEATS_PER_PHASE = 225;
    localparam int          NUM_PHASES      = 8;

    typedef struct packed {
        coord_t     x;
        coord_t     y;
        color_t     color;
        logic       last;
    } pixel_t;

    // one directed row: a byte repeated rep times, with a hand-typed pixel where obvious
    typedef struct packed {
        logic [7:0] rep;
        logic [7:0] fbyte;
        logic       mark;
        logic       typed;
        coord_t     x;
        coord_t     y;
        color_t     color;
        logic       last;
    } stim_row_t;

    // a 2 x 2 image after reset defaults (start 0, 48), no start mark on the first file
    localparam stim_row_t DIRECTED_ROWS [17] = '{
        // header through 0x11 all zero, so the pixel offset is below the header end
        '{8'd18, 8'h00, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        '{8'd1,  8'h02, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},   // width low
        '{8'd1,  8'h00, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},   // width high
        '{8'd2,  8'h00, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        '{8'd1,  8'h02, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},   // height low
        '{8'd1,  8'h00, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},   // height high
        // bottom stored row lands on the lower screen row
        '{8'd2,  8'h00, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        '{8'd1,  8'h00, 1'b0, 1'b1, 13'd0, 13'd49, 24'h000000, 1'b0},
        '{8'd2,  8'hFF, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        '{8'd1,  8'hFF, 1'b0, 1'b1, 13'd1, 13'd49, 24'hFFFFFF, 1'b0},
        // blue, green, red byte order
        '{8'd1,  8'h56, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        '{8'd1,  8'h34, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        '{8'd1,  8'h12, 1'b0, 1'b1, 13'd0, 13'd48, 24'h123456, 1'b0},
        '{8'd2,  8'h00, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        '{8'd1,  8'hFF, 1'b0, 1'b1, 13'd1, 13'd48, 24'hFF0000, 1'b1},
        // byte after the image is dropped
        '{8'd1,  8'hA5, 1'b0, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0},
        // restart mark mid-stream
        '{8'd1,  8'hFF, 1'b1, 1'b0, 13'd0, 13'd0, 24'h000000, 1'b0}
    };

    // dut ports, all inputs known from time zero
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic [7:0]  file_byte   = 8'h00;
    logic        first_byte  = 1'b0;
    logic        byte_valid  = 1'b0;
    logic        byte_ready;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [23:0] pixel_color;
    logic        last;
    logic        pixel_valid;
    logic        pixel_ready = 1'b0;
    logic [1:0]  cfg_index   = CFG_START_X;
    logic [12:0] cfg_data    = 13'd0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;

    // decoder shadow: parse state
    logic [7:0]  hdr_pos;
    logic [7:0]  pix_offset;
    dim_t        img_w;
    dim_t        img_h;
    dim_t        col_cnt;
    dim_t        row_cnt;
    logic [1:0]  tri_phase;
    logic [15:0] bg_partial;
    logic        img_finished;

    // decoder shadow: window registers
    logic [10:0] cur_start_x;
    logic [10:0] cur_start_y;
    logic [12:0] cur_clip_w;
    logic [12:0] cur_clip_h;

    // pixels predicted but not yet seen on the output
    pixel_t      expected_pixels [$];
    pixel_t      mon_want;

    int unsigned beats_sent     = 0;
    int unsigned pixels_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;

    // idling knobs: sender side used by the stimulus, receiver side by its own process
    int unsigned tx_gap_pct     = 0;
    int unsigned rx_stall_pct   = 0;
    logic        hold_off_go    = 1'b0;
    logic        hold_off_done  = 1'b0;
    int unsigned hold_left      = 0;

    bmp24_pixel_stream_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_byte   (file_byte),
        .first_byte  (first_byte),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d pixels still owed",
                     cycle_count, expected_pixels.size());
            $display("bmp24_pixel_stream_decoder: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            pixel_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end
        else if (hold_off_go && !hold_off_done)
        begin
            hold_off_done <= 1'b1;
            hold_left     <= HOLD_OFF_CYCLES;
            pixel_ready   <= 1'b0;
        end
        else
        begin
            pixel_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // pixel beats against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && pixel_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: expected no pixel, got x=%0d y=%0d color=0x%06h last=%0d",
                         $time, pixel_x, pixel_y, pixel_color, last);
            end
            else
            begin
                mon_want = expected_pixels.pop_front();
                check_field("pixel_x", mon_want.x, pixel_x);
                check_field("pixel_y", mon_want.y, pixel_y);
                check_field("pixel_color", mon_want.color, pixel_color);
                check_field("last", mon_want.last, last);
                pixels_checked++;
            end
        end
    end

    function automatic void clear_parse();
        hdr_pos      = '0;
        pix_offset   = '0;
        img_w        = '0;
        img_h        = '0;
        col_cnt      = '0;
        row_cnt      = '0;
        tri_phase    = PHASE_BLUE;
        bg_partial   = '0;
        img_finished = 1'b0;
    endfunction

    // one accepted byte through the shadow decoder; returns 1 when a pixel is drawn
    function automatic bit decode_byte(input logic [7:0] b, input logic mark,
                                       output pixel_t px);
        logic [7:0]  data_start;
        int unsigned draw_w;
        int unsigned draw_h;
        int unsigned col_j;
        int unsigned stored_s;
        color_t      color;

        px = '0;
        if (mark)
            clear_parse();

        // pixel data never starts inside the size fields
        data_start = (pix_offset < HDR_END) ? HDR_END : pix_offset;
        if (hdr_pos < data_start)
        begin
            case (hdr_pos)
                HDR_OFFSET_POS: pix_offset   = b;
                HDR_WIDTH_LO:   img_w[7:0]   = b;
                HDR_WIDTH_HI:   img_w[15:8]  = b;
                HDR_HEIGHT_LO:  img_h[7:0]   = b;
                HDR_HEIGHT_HI:  img_h[15:8]  = b;
                default: ;
            endcase
            hdr_pos = hdr_pos + 8'd1;
            return 1'b0;
        end

        if (img_finished)
            return 1'b0;

        draw_w = (img_w < cur_clip_w) ? img_w : cur_clip_w;
        draw_h = (img_h < cur_clip_h) ? img_h : cur_clip_h;
        if (draw_w == 0 || draw_h == 0)
        begin
            img_finished = 1'b1;
            return 1'b0;
        end

        case (tri_phase)
            PHASE_BLUE:
            begin
                bg_partial = {8'h00, b};
                tri_phase  = PHASE_GREEN;
                return 1'b0;
            end
            PHASE_GREEN:
            begin
                bg_partial[15:8] = b;
                tri_phase        = PHASE_RED;
                return 1'b0;
            end
            default: ;
        endcase

        color     = {b, bg_partial};
        tri_phase = PHASE_BLUE;
        col_j     = col_cnt;
        stored_s  = row_cnt;

        // stride is the true image width, rows wrap at 16 bits
        col_cnt = col_cnt + 16'd1;
        if (col_cnt >= img_w)
        begin
            col_cnt = '0;
            row_cnt = row_cnt + 16'd1;
        end

        if (col_j >= draw_w || stored_s >= draw_h)
            return 1'b0;

        // bottom-up storage, so screen row counts down from the top of the window
        px.x     = coord_t'(cur_start_x + col_j);
        px.y     = coord_t'(cur_start_y + draw_h - 1 - stored_s);
        px.color = color;
        px.last  = (col_j == draw_w - 1) && (stored_s == draw_h - 1);
        if (px.last)
            img_finished = 1'b1;
        return 1'b1;
    endfunction

    // offer one byte beat, wait for the handshake, then predict
    task automatic send_beat(input logic [7:0] b, input logic mark, input logic typed,
                             input pixel_t want);
        pixel_t px;
        bit     got;

        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        file_byte  <= b;
        first_byte <= mark;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        got = decode_byte(b, mark, px);
        if (typed)
            expected_pixels.push_back(want);
        else if (got)
            expected_pixels.push_back(px);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_START_X:     cur_start_x = val[10:0];
            CFG_START_Y:     cur_start_y = val[10:0];
            CFG_CLIP_WIDTH:  cur_clip_w  = val;
            CFG_CLIP_HEIGHT: cur_clip_h  = val;
            default: ;
        endcase
    endtask

    // stop offering, let every owed pixel arrive, then idle for DRAIN_CYCLES
    task automatic settle();
        byte_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // one bitmap file: mostly well-formed small images, some empty, huge, cut or padded
    task automatic send_random_file();
        logic [7:0]  offset_b;
        logic [7:0]  b;
        logic [15:0] width_w;
        logic [15:0] height_w;
        int unsigned hdr_len;
        int unsigned full_len;
        int unsigned pix_len;
        int unsigned pick;
        logic        mark;
        bit          small_img;

        pick = $urandom_range(19);
        if (pick < 8)
            offset_b = 8'($urandom_range(8'h17));
        else if (pick < 17)
            offset_b = 8'($urandom_range(8'h20, 8'h18));
        else if (pick < 19)
            offset_b = 8'($urandom_range(8'h40, 8'h21));
        else
            offset_b = 8'($urandom_range(8'hFF, 8'h41));

        pick = $urandom_range(19);
        if (pick == 0)
            width_w = 16'd0;
        else if (pick == 1)
            width_w = 16'($urandom_range(16'hFFFF, 16'h0100));
        else if (pick == 2)
            width_w = 16'hFFFF;
        else
            width_w = 16'($urandom_range(6, 1));

        pick = $urandom_range(19);
        if (pick == 0)
            height_w = 16'd0;
        else if (pick == 1)
            height_w = 16'($urandom_range(16'hFFFF, 16'h0100));
        else
            height_w = 16'($urandom_range(5, 1));

        small_img = (width_w != 0) && (width_w <= 6) && (height_w != 0) && (height_w <= 5);
        if (width_w == 0 || height_w == 0)
            full_len = $urandom_range(3);
        else if (small_img)
            full_len = 3 * width_w * height_w;
        else
            full_len = $urandom_range(48, 3);

        // truncated, padded past the image, or exact
        pick = $urandom_range(9);
        if (pick == 0)
            pix_len = (full_len == 0) ? 0 : $urandom_range(full_len - 1);
        else if (pick == 1)
            pix_len = full_len + $urandom_range(6, 1);
        else
            pix_len = full_len;

        // now and then a file with no start mark
        mark    = ($urandom_range(24) != 0);
        hdr_len = (offset_b < HDR_END) ? HDR_END : offset_b;
        for (int unsigned k = 0; k < hdr_len; k++)
        begin
            case (k)
                HDR_OFFSET_POS: b = offset_b;
                HDR_WIDTH_LO:   b = width_w[7:0];
                HDR_WIDTH_HI:   b = width_w[15:8];
                HDR_HEIGHT_LO:  b = height_w[7:0];
                HDR_HEIGHT_HI:  b = height_w[15:8];
                default:        b = 8'($urandom);
            endcase
            send_beat(b, (k == 0) ? mark : 1'b0, 1'b0, '0);
        end

        repeat (pix_len)
            send_beat(8'($urandom), 1'b0, 1'b0, '0);

        // stray beats, sometimes a lone restart mark
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(4, 1))
                send_beat(8'($urandom), ($urandom_range(9) == 0), 1'b0, '0);
    endtask

    initial
    begin
        stim_row_t   step_row;
        logic [10:0] set_x;
        logic [10:0] set_y;
        logic [12:0] set_w;
        logic [12:0] set_h;
        int unsigned phase_start;
        int unsigned idle_kind;

        cur_start_x = START_X_RST;
        cur_start_y = START_Y_RST;
        cur_clip_w  = CLIP_WIDTH_RST;
        cur_clip_h  = CLIP_HEIGHT_RST;
        clear_parse();

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table on reset register values
        for (int r = 0; r < 17; r++)
        begin
            step_row = DIRECTED_ROWS[r];
            for (int k = 0; k < step_row.rep; k++)
                send_beat(step_row.fbyte, step_row.mark, step_row.typed,
                          {step_row.x, step_row.y, step_row.color, step_row.last});
        end
        settle();

        // random files under changing windows and idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    // smallest window at the origin
                    set_x = 11'd0;
                    set_y = 11'd0;
                    set_w = 13'd1;
                    set_h = 13'd1;
                end
                1:
                begin
                    // largest offsets, clips at 4096
                    set_x = 11'd2047;
                    set_y = 11'd2047;
                    set_w = 13'd4096;
                    set_h = 13'd4096;
                end
                2:
                begin
                    set_x = 11'($urandom_range(2047));
                    set_y = 11'($urandom_range(2047));
                    set_w = 13'($urandom_range(8, 1));
                    set_h = 13'($urandom_range(6, 1));
                end
                3:
                begin
                    set_x = 11'($urandom_range(2047));
                    set_y = 11'($urandom_range(2047));
                    set_w = 13'd4096;
                    set_h = 13'($urandom_range(4096, 1));
                end
                4:
                begin
                    set_x = START_X_RST;
                    set_y = START_Y_RST;
                    set_w = CLIP_WIDTH_RST;
                    set_h = CLIP_HEIGHT_RST;
                end
                5:
                begin
                    // clip cuts most images
                    set_x = 11'($urandom_range(2047));
                    set_y = 11'($urandom_range(2047));
                    set_w = 13'd2;
                    set_h = 13'd3;
                end
                6:
                begin
                    set_x = 11'($urandom_range(2047));
                    set_y = 11'($urandom_range(2047));
                    set_w = 13'($urandom_range(4096, 1));
                    set_h = 13'($urandom_range(4096, 1));
                end
                default:
                begin
                    set_x = 11'($urandom_range(2047));
                    set_y = 11'($urandom_range(2047));
                    set_w = 13'($urandom_range(4, 1));
                    set_h = 13'($urandom_range(4, 1));
                end
            endcase

            // block is idle here: all owed pixels in and drain cycles spent
            write_reg(CFG_START_X, {2'b00, set_x});
            write_reg(CFG_START_Y, {2'b00, set_y});
            write_reg(CFG_CLIP_WIDTH, set_w);
            write_reg(CFG_CLIP_HEIGHT, set_h);
            cfg_valid <= 1'b0;

            // none, sender gaps, receiver stalls, both light
            idle_kind    = ph % 4;
            tx_gap_pct   = (idle_kind == 1) ? 83 : (idle_kind == 3) ? 16 : 0;
            rx_stall_pct <= (idle_kind == 2) ? 83 : (idle_kind == 3) ? 16 : 0;

            // long receiver hold-off while the sender keeps pushing beats
            if (ph == 4)
                hold_off_go <= 1'b1;

            phase_start = beats_sent;
            while (beats_sent - phase_start < BEATS_PER_PHASE)
                send_random_file();
            settle();
        end

        $display("covered %0d byte beats and %0d checked pixels over %0d window settings",
                 beats_sent, pixels_checked, NUM_PHASES);
        $display("idling mixes: none, sender gaps, receiver stalls, both, one long hold-off");
        if (mismatches == 0)
            $display("bmp24_pixel_stream_decoder: match");
        else
            $display("bmp24_pixel_stream_decoder: mismatch");
        $finish;
    end

endmodule
